// ===== design/kint_pkg.sv =====
// Shared types and constants of the keyword/identifier/number tokenizer.
package kint_pkg;

    // Token kinds
    localparam logic [2:0] KIND_KEYWORD = 3'd0;
    localparam logic [2:0] KIND_IDENT   = 3'd1;
    localparam logic [2:0] KIND_NUMBER  = 3'd2;
    localparam logic [2:0] KIND_SYMBOL  = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    // Saturation limit of a token length and kept identifier prefix bytes
    localparam logic [15:0] LEN_MAX      = 16'hFFFF;
    localparam int          PREFIX_BYTES = 6;

    // Keyword table, first character in the low byte, unused bytes zero
    localparam int KW_COUNT = 7;
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'h0000_0066_6564,   // def
        48'h0000_0074_6E69,   // int
        48'h0000_0000_6669,   // if
        48'h0000_6573_6C65,   // else
        48'h6E72_7574_6572,   // return
        48'h0065_6C69_6877,   // while
        48'h0000_6669_6C65    // elif
    };
    localparam logic [15:0] KW_LEN [KW_COUNT] = '{
        16'd3, 16'd3, 16'd2, 16'd4, 16'd6, 16'd5, 16'd4
    };

    // Scan state
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_IDENT  = 3'b010,
        MODE_NUMBER = 3'b100
    } t_mode;

    // One input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_input;
    } t_item;

    // One result item
    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [2:0]  keyword_index;
        logic [7:0]  symbol_byte;
        logic        last_of_run;
    } t_token;

    // All tokens caused by one item, in order
    typedef struct packed {
        t_token [2:0] slots;
        logic   [1:0] count;
    } t_bundle;

endpackage

// ===== design/kint_if.sv =====
// Valid/ready channel interfaces for input characters and output tokens.
interface kint_item_if;
    logic           valid;
    logic           ready;
    kint_pkg::t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kint_token_if;
    logic            valid;
    logic            ready;
    kint_pkg::t_token data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/kint_scan.sv =====
// Scan state and per-character classification; builds the token bundle of one item.
module kint_scan #(
    parameter int POSITION_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  kint_pkg::t_item   i_item,
    input  logic              i_emit_ready,
    output logic              o_commit,
    output logic              o_bundle_valid,
    output kint_pkg::t_bundle o_bundle
);

    kint_pkg::t_mode            r_mode, n_mode;
    logic [POSITION_WIDTH-1:0]  r_pos, n_pos;
    logic [15:0]                r_start, n_start;
    logic [15:0]                r_len, n_len;
    logic [47:0]                r_prefix, n_prefix;

    logic [7:0]  c;
    logic        is_alpha, is_digit, is_punct;
    logic [31:0] here_wide;
    logic [15:0] here16;

    // Build the token that closes an open identifier or number
    function automatic kint_pkg::t_token close_tok(input kint_pkg::t_mode mode,
                                                    input logic [15:0] start,
                                                    input logic [15:0] len,
                                                    input logic [47:0] prefix);
        kint_pkg::t_token tok;
        tok = '0;
        tok.token_start  = start;
        tok.token_length = len;
        if (mode == kint_pkg::MODE_IDENT) begin
            tok.token_kind = kint_pkg::KIND_IDENT;
            for (int k = kint_pkg::KW_COUNT - 1; k >= 0; k--) begin
                if (len == kint_pkg::KW_LEN[k] && prefix == kint_pkg::KW_TEXT[k]) begin
                    tok.token_kind    = kint_pkg::KIND_KEYWORD;
                    tok.keyword_index = 3'(k);
                end
            end
        end else begin
            tok.token_kind = kint_pkg::KIND_NUMBER;
        end
        return tok;
    endfunction

    assign c          = i_item.data_byte;
    assign is_alpha   = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    assign is_digit   = (c >= 8'h30 && c <= 8'h39);
    assign is_punct   = (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
                        (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    assign here_wide  = 32'(r_pos);
    assign here16     = here_wide[15:0];

    // Next scan state and the ordered list of tokens for this item
    always_comb begin
        kint_pkg::t_token sym_tok;
        kint_pkg::t_token end_tok;
        logic [31:0]      after_wide;
        n_mode     = r_mode;
        n_pos      = r_pos;
        n_start    = r_start;
        n_len      = r_len;
        n_prefix   = r_prefix;
        o_bundle   = '0;
        sym_tok    = '0;
        end_tok    = '0;
        after_wide = '0;

        if (i_item.has_byte) begin
            n_pos = r_pos + POSITION_WIDTH'(1);
            if (r_mode == kint_pkg::MODE_IDENT && (is_alpha || is_digit)) begin
                for (int b = 0; b < kint_pkg::PREFIX_BYTES; b++) begin
                    if (r_len == 16'(b)) n_prefix[8*b +: 8] = c;
                end
                if (r_len != kint_pkg::LEN_MAX) n_len = r_len + 16'd1;
            end else if (r_mode == kint_pkg::MODE_NUMBER && is_digit) begin
                if (r_len != kint_pkg::LEN_MAX) n_len = r_len + 16'd1;
            end else begin
                // close whatever was open
                if (r_mode != kint_pkg::MODE_IDLE) begin
                    o_bundle.slots[o_bundle.count] = close_tok(r_mode, r_start, r_len, r_prefix);
                    o_bundle.count = o_bundle.count + 2'd1;
                end
                n_mode   = kint_pkg::MODE_IDLE;
                n_start  = '0;
                n_len    = '0;
                n_prefix = '0;
                if (is_alpha) begin
                    n_mode   = kint_pkg::MODE_IDENT;
                    n_start  = here16;
                    n_len    = 16'd1;
                    n_prefix = 48'(c);
                end else if (is_digit) begin
                    n_mode  = kint_pkg::MODE_NUMBER;
                    n_start = here16;
                    n_len   = 16'd1;
                end else if (is_punct) begin
                    sym_tok.token_kind   = kint_pkg::KIND_SYMBOL;
                    sym_tok.token_start  = here16;
                    sym_tok.token_length = 16'd1;
                    sym_tok.symbol_byte  = c;
                    o_bundle.slots[o_bundle.count] = sym_tok;
                    o_bundle.count = o_bundle.count + 2'd1;
                end
            end
        end

        if (i_item.end_of_input) begin
            // flush the open token, then the end marker, then start over
            if (n_mode != kint_pkg::MODE_IDLE) begin
                o_bundle.slots[o_bundle.count] = close_tok(n_mode, n_start, n_len, n_prefix);
                o_bundle.count = o_bundle.count + 2'd1;
            end
            after_wide          = 32'(n_pos);
            end_tok.token_kind  = kint_pkg::KIND_END;
            end_tok.token_start = after_wide[15:0];
            o_bundle.slots[o_bundle.count] = end_tok;
            o_bundle.count = o_bundle.count + 2'd1;
            n_mode   = kint_pkg::MODE_IDLE;
            n_pos    = '0;
            n_start  = '0;
            n_len    = '0;
            n_prefix = '0;
        end
    end

    assign o_bundle_valid = i_valid && (o_bundle.count != 2'd0);
    assign o_commit       = i_valid && ((o_bundle.count == 2'd0) || i_emit_ready);

    // Advance the scan state on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= kint_pkg::MODE_IDLE;
            r_pos    <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_prefix <= '0;
        end else if (o_commit) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_len    <= n_len;
            r_prefix <= n_prefix;
        end
    end

endmodule

// ===== design/kint_emit.sv =====
// Result register: holds one token bundle and hands its tokens out one per transfer.
module kint_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load_valid,
    input  kint_pkg::t_bundle i_bundle,
    output logic              o_load_ready,
    kint_token_if.source      o_token
);

    kint_pkg::t_bundle r_bun;
    logic [1:0]        r_idx;
    logic              r_valid;
    logic              last;
    logic              xfer;
    kint_pkg::t_token  cur;

    assign last = (r_idx == (r_bun.count - 2'd1));
    assign xfer = r_valid && o_token.ready;
    assign o_load_ready = !r_valid || (xfer && last);

    // Present the current token with its end-of-run flag
    always_comb begin
        cur             = r_bun.slots[r_idx];
        cur.last_of_run = last;
    end

    assign o_token.valid = r_valid;
    assign o_token.data  = cur;

    // Hold the bundle; step through it on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load_valid && o_load_ready) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (xfer) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_valid && o_load_ready) begin
            r_bun <= i_bundle;
        end
    end

endmodule

// ===== design/keyword_ident_number_tokenizer_top.sv =====
// Tokenizer top level: input register, scanner and token output register.
// Takes one ASCII byte per transfer and emits keyword, identifier, number,
// symbol and end tokens, one token per output transfer. An input item is
// accepted every cycle while the receiver is ready and each item yields at
// most one token; an item that yields k tokens (at most three: a closed
// token, a symbol or an open token flushed by end of input, and the end
// token) holds the input side until the output register has handed out all
// k, since it drains one token per cycle while the receiver is ready. The
// first token of an item passes the input register and the output register
// before it is offered. The position counter is POSITION_WIDTH bits wide
// and wraps; reported offsets are its low 16 bits. Lengths saturate at
// 65535. After the end token the next byte starts a new text at offset 0.
module keyword_ident_number_tokenizer_top #(
    parameter int POSITION_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kint_item_if.sink   i_item,
    kint_token_if.source o_token
);

    logic              r_in_valid;
    kint_pkg::t_item   r_in;
    logic              commit;
    logic              bundle_valid;
    logic              emit_ready;
    kint_pkg::t_bundle bundle;

    assign i_item.ready = !r_in_valid || commit;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.data;
        end
    end

    kint_scan #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_in_valid),
        .i_item         (r_in),
        .i_emit_ready   (emit_ready),
        .o_commit       (commit),
        .o_bundle_valid (bundle_valid),
        .o_bundle       (bundle)
    );

    kint_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (bundle_valid),
        .i_bundle     (bundle),
        .o_load_ready (emit_ready),
        .o_token      (o_token)
    );

`ifndef SYNTHESIS
    // A waiting item stays put until the scanner takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !commit |=> r_in_valid && $stable(r_in))
        else $error("input register changed before commit");

    // End token has zero length and closes the run
    a_end_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_token.valid && o_token.data.token_kind == kint_pkg::KIND_END |->
        o_token.data.token_length == 16'd0 && o_token.data.last_of_run)
        else $error("malformed end token");

    // Symbols are one byte long and carry a nonzero byte
    a_sym_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_token.valid && o_token.data.token_kind == kint_pkg::KIND_SYMBOL |->
        o_token.data.token_length == 16'd1 && o_token.data.symbol_byte != 8'd0)
        else $error("malformed symbol token");

    // Keyword index only on keyword tokens
    a_kw_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_token.valid && o_token.data.keyword_index != 3'd0 |->
        o_token.data.token_kind == kint_pkg::KIND_KEYWORD)
        else $error("keyword index on non-keyword token");
`endif

endmodule

// ===== sim/keyword_ident_number_tokenizer_top_test.sv =====
// Self-checking testbench for the keyword/identifier/number tokenizer top level.
`timescale 1ns / 1ps

module keyword_ident_number_tokenizer_top_test;

    localparam logic [15:0] SAT_LEN      = 16'hFFFF;
    localparam int          PREFIX_KEEP  = 6;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          IDLE_LIMIT   = 4000;
    localparam int          SETTLE_CYCLES = 20;

    // One pending input character with its lead-in gap
    typedef struct {
        kint_pkg::t_item item;
        int unsigned     gap;
        bit              wait_drain;
    } t_char_slot;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kint_item_if  item_ch ();
    kint_token_if token_ch ();

    keyword_ident_number_tokenizer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_token (token_ch)
    );

    string keyword_text [7] = '{"def", "int", "if", "else", "return", "while", "elif"};
    string near_keywords [10] = '{"de", "ints", "iff", "els", "returns", "whil", "elifs",
                                  "Def", "IF", "While"};

    t_char_slot        pending_chars [$];
    kint_pkg::t_token  expected_tokens [$];
    kint_pkg::t_token  item_tokens [$];

    // Scanner state of the predictor
    kint_pkg::t_mode lex_mode;
    logic [15:0]     lex_pos;
    logic [15:0]     open_start;
    logic [15:0]     open_len;
    logic [47:0]     open_prefix;

    int unsigned gap_max;
    bit          hold_for_drain;
    int unsigned live_items;
    int unsigned mismatch_count;
    int unsigned tokens_seen;
    int unsigned stalled_cycles = 0;

    // Driver state
    t_char_slot  next_slot;
    bit          offering;
    bit          staged;
    int unsigned gap_left;

    // Receiver state
    bit          rx_calm;
    int unsigned rx_wait;
    int unsigned rx_hold;

    always #2 i_clk = ~i_clk;

    function automatic bit is_letter(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit is_punct(logic [7:0] c);
        return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
               (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

    function automatic kint_pkg::t_token make_token(logic [2:0] kind, logic [15:0] start,
                                                    logic [15:0] len, logic [2:0] kw,
                                                    logic [7:0] sym);
        kint_pkg::t_token tok;
        tok.token_kind    = kind;
        tok.token_start   = start;
        tok.token_length  = len;
        tok.keyword_index = kw;
        tok.symbol_byte   = sym;
        tok.last_of_run   = 1'b0;
        return tok;
    endfunction

    // Emit the open identifier or number, if any, and drop back to between tokens
    task automatic close_open_token();
        logic [2:0] kind;
        logic [2:0] kw_idx;
        bit         same;
        if (lex_mode == kint_pkg::MODE_IDENT) begin
            kind   = kint_pkg::KIND_IDENT;
            kw_idx = 3'd0;
            for (int k = 0; k < 7; k++) begin
                same = (kind == kint_pkg::KIND_IDENT) &&
                       (open_len == 16'(keyword_text[k].len()));
                for (int i = 0; same && i < keyword_text[k].len(); i++) begin
                    if (open_prefix[8*i +: 8] != keyword_text[k][i]) same = 1'b0;
                end
                if (same) begin
                    kind   = kint_pkg::KIND_KEYWORD;
                    kw_idx = 3'(k);
                end
            end
            item_tokens.insert(item_tokens.size(),
                               make_token(kind, open_start, open_len, kw_idx, 8'd0));
        end else if (lex_mode == kint_pkg::MODE_NUMBER) begin
            item_tokens.insert(item_tokens.size(),
                               make_token(kint_pkg::KIND_NUMBER, open_start, open_len,
                                          3'd0, 8'd0));
        end
        lex_mode    = kint_pkg::MODE_IDLE;
        open_start  = '0;
        open_len    = '0;
        open_prefix = '0;
    endtask

    // Work out the tokens one accepted character causes and queue them
    task automatic predict_tokens(kint_pkg::t_item it);
        logic [7:0]       c;
        logic [15:0]      here;
        kint_pkg::t_token tok;
        c = it.data_byte;
        item_tokens.delete();
        if (it.has_byte) begin
            here = lex_pos;
            if (lex_mode == kint_pkg::MODE_IDENT && (is_letter(c) || is_digit(c))) begin
                if (open_len < PREFIX_KEEP) open_prefix[8*open_len +: 8] = c;
                if (open_len != SAT_LEN) open_len++;
            end else if (lex_mode == kint_pkg::MODE_NUMBER && is_digit(c)) begin
                if (open_len != SAT_LEN) open_len++;
            end else begin
                close_open_token();
                if (is_letter(c)) begin
                    lex_mode    = kint_pkg::MODE_IDENT;
                    open_start  = here;
                    open_len    = 16'd1;
                    open_prefix = {40'd0, c};
                end else if (is_digit(c)) begin
                    lex_mode   = kint_pkg::MODE_NUMBER;
                    open_start = here;
                    open_len   = 16'd1;
                end else if (is_punct(c)) begin
                    item_tokens.insert(item_tokens.size(),
                                       make_token(kint_pkg::KIND_SYMBOL, here, 16'd1,
                                                  3'd0, c));
                end
            end
            lex_pos = here + 16'd1;
        end
        if (it.end_of_input) begin
            close_open_token();
            item_tokens.insert(item_tokens.size(),
                               make_token(kint_pkg::KIND_END, lex_pos, 16'd0, 3'd0, 8'd0));
            lex_pos = '0;
        end
        foreach (item_tokens[i]) begin
            tok = item_tokens[i];
            tok.last_of_run = (i == item_tokens.size() - 1);
            expected_tokens.insert(expected_tokens.size(), tok);
        end
    endtask

    task automatic note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 40) $display("MISMATCH at token %0d: %s", tokens_seen, what);
    endtask

    // Stimulus helpers
    task automatic queue_item(logic [7:0] b, bit has, bit fin);
        t_char_slot slot;
        slot.item.data_byte    = b;
        slot.item.has_byte     = has;
        slot.item.end_of_input = fin;
        slot.gap               = $urandom_range(0, gap_max);
        slot.wait_drain        = hold_for_drain;
        hold_for_drain         = 1'b0;
        pending_chars.insert(pending_chars.size(), slot);
        if (has || fin) live_items++;
    endtask

    task automatic send_byte(logic [7:0] b);
        queue_item(b, 1'b1, 1'b0);
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function automatic logic [7:0] random_alnum();
        case ($urandom_range(0, 2))
            0: return 8'h41 + 8'($urandom_range(0, 25));
            1: return 8'h61 + 8'($urandom_range(0, 25));
            default: return 8'h30 + 8'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [7:0] random_punct();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(8'h21, 8'h2F));
            1: return 8'($urandom_range(8'h3A, 8'h40));
            2: return 8'($urandom_range(8'h5B, 8'h60));
            default: return 8'($urandom_range(8'h7B, 8'h7E));
        endcase
    endfunction

    // Queue one word: keyword, near miss, number or identifier
    task automatic send_word();
        case ($urandom_range(0, 5))
            0: send_string(keyword_text[$urandom_range(0, 6)]);
            1: send_string(near_keywords[$urandom_range(0, 9)]);
            2: repeat ($urandom_range(1, 6)) send_byte(8'h30 + 8'($urandom_range(0, 9)));
            3: begin
                send_byte(8'h61 + 8'($urandom_range(0, 25)));
                repeat ($urandom_range(0, 9)) send_byte(random_alnum());
            end
            4: begin
                send_string(keyword_text[$urandom_range(0, 6)]);
                repeat ($urandom_range(1, 2)) send_byte(8'h30 + 8'($urandom_range(0, 9)));
            end
            default: begin
                send_string("return");
                repeat ($urandom_range(1, 6)) send_byte(random_alnum());
            end
        endcase
    endtask

    // Queue what stands between words; sometimes nothing, so words run together
    task automatic send_separator();
        case ($urandom_range(0, 5))
            0: send_byte(8'h20);
            1: send_byte(8'($urandom_range(8'h09, 8'h0D)));
            2: send_byte(random_punct());
            3: send_byte(8'($urandom_range(8'h80, 8'hFF)));
            4: send_byte(($urandom_range(0, 1) == 0) ? 8'h7F : 8'($urandom_range(0, 8)));
            default: ;
        endcase
    endtask

    // Sender: offer queued characters after their gaps; predict on each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            item_ch.data  <= '0;
            offering    = 1'b0;
            staged      = 1'b0;
            gap_left    = 0;
            lex_mode    = kint_pkg::MODE_IDLE;
            lex_pos     = '0;
            open_start  = '0;
            open_len    = '0;
            open_prefix = '0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                predict_tokens(item_ch.data);
                offering = 1'b0;
            end
            if (!offering && !staged && pending_chars.size() > 0 &&
                (!pending_chars[0].wait_drain || expected_tokens.size() == 0)) begin
                next_slot = pending_chars.pop_front();
                gap_left  = next_slot.gap;
                staged    = 1'b1;
            end
            if (staged) begin
                if (gap_left == 0) begin
                    item_ch.data <= next_slot.item;
                    offering = 1'b1;
                    staged   = 1'b0;
                end else begin
                    gap_left--;
                end
            end
            item_ch.valid <= offering;
        end
    end

    // Receiver: check each token transfer, then stall at random or hold off
    always @(posedge i_clk) begin
        kint_pkg::t_token got;
        kint_pkg::t_token want;
        if (!i_rst_n) begin
            token_ch.ready <= 1'b0;
            rx_wait        = 0;
            rx_hold        = 0;
            rx_calm        = 1'b0;
            mismatch_count = 0;
            tokens_seen    = 0;
        end else begin
            if (token_ch.valid && token_ch.ready) begin
                got = token_ch.data;
                if (expected_tokens.size() == 0) begin
                    note_mismatch($sformatf("unexpected token kind %0d start %0d",
                                            got.token_kind, got.token_start));
                end else begin
                    want = expected_tokens.pop_front();
                    if (got.token_kind !== want.token_kind)
                        note_mismatch($sformatf("kind %0d, want %0d",
                                                got.token_kind, want.token_kind));
                    if (got.token_start !== want.token_start)
                        note_mismatch($sformatf("start %0d, want %0d",
                                                got.token_start, want.token_start));
                    if (got.token_length !== want.token_length)
                        note_mismatch($sformatf("length %0d, want %0d",
                                                got.token_length, want.token_length));
                    if (got.keyword_index !== want.keyword_index)
                        note_mismatch($sformatf("keyword index %0d, want %0d",
                                                got.keyword_index, want.keyword_index));
                    if (got.symbol_byte !== want.symbol_byte)
                        note_mismatch($sformatf("symbol byte %h, want %h",
                                                got.symbol_byte, want.symbol_byte));
                    if (got.last_of_run !== want.last_of_run)
                        note_mismatch($sformatf("last flag %b, want %b",
                                                got.last_of_run, want.last_of_run));
                end
                tokens_seen++;
                if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 12);
                if (tokens_seen == 30 || tokens_seen == 120) rx_hold = HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                token_ch.ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                token_ch.ready <= 1'b0;
            end else begin
                token_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (token_ch.valid && token_ch.ready)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
            if (stalled_cycles >= IDLE_LIMIT) begin
                $display("keyword_ident_number_tokenizer_top_test: done, errors");
                $finish;
            end
        end
    end

    initial begin
        bit mid_drain;
        mid_drain      = 1'b0;
        i_rst_n        = 1'b0;
        hold_for_drain = 1'b0;
        live_items     = 0;

        // Directed text: every token kind, skipped bytes
        gap_max = 12;
        send_string("10a");                 // number then identifier
        queue_item(8'hFF, 1'b0, 1'b0);      // neither byte nor end: nothing
        send_byte(8'h20);
        send_string("while");
        send_byte(8'h80);                   // high byte closes the keyword
        send_string("x1");
        send_byte(8'h00);                   // control byte
        send_string("def");
        send_byte(8'h7F);
        send_string("9");
        queue_item(8'h2B, 1'b1, 1'b1);      // number, symbol and end at once
        queue_item(8'h00, 1'b0, 1'b1);      // bare end at offset 0
        send_string("elif");
        queue_item(8'hA5, 1'b0, 1'b1);      // end with no byte flushes the keyword
        send_string("int{if}else");
        queue_item(8'h7E, 1'b1, 1'b1);

        // Random texts, mostly well formed, with some noise between them
        hold_for_drain = 1'b1;
        while (live_items < 280) begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            if (!mid_drain && live_items > 140) begin
                hold_for_drain = 1'b1;
                mid_drain      = 1'b1;
            end
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 8))
                    queue_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
                               $urandom_range(0, 7) == 0);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_word();
                    send_separator();
                end
                queue_item(8'($urandom_range(0, 255)), $urandom_range(0, 1) == 0, 1'b1);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last transfer and its tokens, then let the pipeline settle
        while (pending_chars.size() != 0 || offering || staged || expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("keyword_ident_number_tokenizer_top_test: done, clean");
        end else begin
            $display("keyword_ident_number_tokenizer_top_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/kint_pkg.sv
design/kint_if.sv
design/kint_scan.sv
design/kint_emit.sv
design/keyword_ident_number_tokenizer_top.sv
sim/keyword_ident_number_tokenizer_top_test.sv
